// ----- design/fsa_pkg.sv -----
package fsa_pkg;

    localparam int CW = 13;
    localparam int LEN_BITS = 48;
    localparam int CFG_BITS = 48;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_ADD     = 2'd2,
        KIND_RECLAIM = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_DROPPED = 2'd2
    } status_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESERVE_BEGIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESERVE_END   = 2'd2;

    localparam logic [CW-1:0] CAPACITY_RESET = 13'd4096;

    typedef struct packed {
        logic [CW-1:0]       capacity;
        logic [CFG_BITS-1:0] reserve_begin;
        logic [CFG_BITS-1:0] reserve_end;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_JUMP,
        ST_FINISH
    } state_t;

endpackage

// ----- design/fsa_if.sv -----
interface fsa_req_if #(
    parameter int ADDR_BITS = 48
);
    import fsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_BITS-1:0]  region_length;

    modport source (output valid, output kind, output address, output region_length,
                    input ready);
    modport sink (input valid, input kind, input address, input region_length,
                  output ready);
endinterface

interface fsa_rsp_if #(
    parameter int ADDR_BITS = 48
);
    import fsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] frame_addr;
    logic [1:0]           status;
    logic [CW-1:0]        free_count;
    logic [CW-1:0]        pushed_count;

    modport source (output valid, output frame_addr, output status, output free_count,
                    output pushed_count, input ready);
    modport sink (input valid, input frame_addr, input status, input free_count,
                  input pushed_count, output ready);
endinterface

// ----- design/fsa_stack_mem.sv -----
module fsa_stack_mem #(
    parameter int DEPTH = 4096,
    parameter int ADDR_BITS = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [ADDR_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [ADDR_BITS-1:0] rd_data
);

    logic [ADDR_BITS-1:0] mem [DEPTH];
    logic [ADDR_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/fsa_ctrl.sv -----
module fsa_ctrl #(
    parameter int DEPTH = 4096,
    parameter int FRAME_BYTES = 4096,
    parameter int ADDR_BITS = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fsa_req_if.sink              request,
    fsa_rsp_if.source            result,
    input  fsa_pkg::cfg_t        cfg,
    output logic                 mem_wr_en,
    output logic [AW-1:0]        mem_wr_addr,
    output logic [ADDR_BITS-1:0] mem_wr_data,
    output logic                 mem_rd_en,
    output logic [AW-1:0]        mem_rd_addr,
    input  logic [ADDR_BITS-1:0] mem_rd_data
);
    import fsa_pkg::*;

    localparam int WW = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;
    localparam logic [WW-1:0] LIMIT = WW'(1) << ADDR_BITS;
    localparam logic [WW-1:0] FSTEP = WW'(FRAME_BYTES);
    localparam logic [WW-1:0] FMASK = FSTEP - WW'(1);

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    status_t              status_reg, status_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pushed_reg, pushed_next;
    logic [WW-1:0]        cur_reg, cur_next;
    logic [WW-1:0]        end_reg, end_next;
    logic [WW-1:0]        re_up_reg, re_up_next;
    logic [WW-1:0]        delta_reg, delta_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0] frame_reg, frame_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [CW-1:0]        free_count_reg, free_count_next;
    logic [CW-1:0]        pushed_count_reg, pushed_count_next;

    kind_t                req_kind;
    logic                 full;
    logic                 in_range;
    logic                 skip;
    logic                 slot_free;
    logic [WW-1:0]        rb_ext, re_ext;

    assign req_kind  = kind_t'(request.kind);
    assign rb_ext    = WW'(cfg.reserve_begin);
    assign re_ext    = WW'(cfg.reserve_end);
    assign full      = (count_reg >= cfg.capacity) || (32'(count_reg) >= 32'(DEPTH));
    assign in_range  = (cur_reg < end_reg) && (cur_reg < LIMIT);
    assign skip      = (kind_reg == KIND_ADD) && (re_ext > rb_ext) && (cur_reg >= rb_ext)
                       && (cur_reg < re_ext);
    assign slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    if (req_kind inside {KIND_ALLOC, KIND_FREE})
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (!in_range)
                begin
                    state_next = ST_FINISH;
                end
                else if (skip)
                begin
                    state_next = ST_JUMP;
                end
                else if (full)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_JUMP:
            begin
                state_next = ST_WALK;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next         = kind_reg;
        status_next       = status_reg;
        count_next        = count_reg;
        pushed_next       = pushed_reg;
        cur_next          = cur_reg;
        end_next          = end_reg;
        re_up_next        = re_up_reg;
        delta_next        = delta_reg;
        out_valid_next    = out_valid_reg;
        frame_next        = frame_reg;
        out_status_next   = out_status_reg;
        free_count_next   = free_count_reg;
        pushed_count_next = pushed_count_reg;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = AW'(count_reg);
        mem_wr_data       = cur_reg[ADDR_BITS-1:0];
        mem_rd_en         = 1'b0;
        mem_rd_addr       = AW'(count_reg - CW'(1));
        request.ready     = (state_reg == ST_IDLE);

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    kind_next   = req_kind;
                    status_next = STATUS_OK;
                    pushed_next = '0;
                    cur_next    = WW'(request.address);
                    end_next    = WW'(request.address) + WW'(request.region_length);
                    re_up_next  = re_ext + FMASK;
                    case (req_kind)
                        KIND_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        KIND_FREE:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_DROPPED;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = request.address;
                                count_next  = count_reg + CW'(1);
                                pushed_next = CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (in_range)
                begin
                    if (skip)
                    begin
                        delta_next = re_up_reg - cur_reg;
                    end
                    else if (full)
                    begin
                        status_next = STATUS_DROPPED;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        count_next  = count_reg + CW'(1);
                        pushed_next = pushed_reg + CW'(1);
                        cur_next    = cur_reg + FSTEP;
                    end
                end
            end
            ST_JUMP:
            begin
                cur_next = cur_reg + (delta_reg & ~FMASK);
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    frame_next        = ((kind_reg == KIND_ALLOC) && (status_reg == STATUS_OK))
                                        ? mem_rd_data : '0;
                    out_status_next   = status_reg;
                    free_count_next   = count_reg;
                    pushed_count_next = pushed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        status_reg       <= status_next;
        pushed_reg       <= pushed_next;
        cur_reg          <= cur_next;
        end_reg          <= end_next;
        re_up_reg        <= re_up_next;
        delta_reg        <= delta_next;
        frame_reg        <= frame_next;
        out_status_reg   <= out_status_next;
        free_count_reg   <= free_count_next;
        pushed_count_reg <= pushed_count_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.frame_addr    = frame_reg;
    assign result.status        = out_status_reg;
    assign result.free_count    = free_count_reg;
    assign result.pushed_count  = pushed_count_reg;

endmodule

// ----- design/free_stack_frame_allocator.sv -----
// Physical frame allocator that keeps free frame addresses on a last-in first-out stack held
// in a synchronous memory with a registered read, one item in flight at a time with one
// result per item. An allocate or a single free passes through the transfer cycle, which
// issues the memory read or write, and the FINISH state, which loads the result register.
// A region item walks the region in the WALK state, pushing frames while the stack has
// room; an add item also steps over the reserved window through the JUMP state. A walk
// that finds the stack full ends in the cycle that would otherwise have pushed the next
// frame. At most min(capacity, DEPTH) frames can be pushed. A finished item waits in the
// FINISH state while the previous result is still held in the output register. FRAME_BYTES
// must be a power of two. The stack memory needs no clearing pass, so items are taken right
// after reset. A finished result waits in the output register while the block is ready for
// the next item.
module free_stack_frame_allocator #(
    parameter int DEPTH = 4096,
    parameter int FRAME_BYTES = 4096,
    parameter int ADDR_BITS = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    fsa_req_if.sink                              request,
    fsa_rsp_if.source                            result,
    input  logic                                 cfg_wr_en,
    input  logic [fsa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fsa_pkg::CFG_BITS-1:0]         cfg_data
);
    import fsa_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cfg_t                 cfg_reg;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [ADDR_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [ADDR_BITS-1:0] mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity      <= CAPACITY_RESET;
            cfg_reg.reserve_begin <= '0;
            cfg_reg.reserve_end   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CAPACITY:      cfg_reg.capacity      <= cfg_data[CW-1:0];
                CFG_RESERVE_BEGIN: cfg_reg.reserve_begin <= cfg_data;
                CFG_RESERVE_END:   cfg_reg.reserve_end   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fsa_stack_mem #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fsa_ctrl #(
        .DEPTH       (DEPTH),
        .FRAME_BYTES (FRAME_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .result      (result),
        .cfg         (cfg_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

endmodule
